/* sv/drd_pkg.sv */
`timescale 1ns / 1ps
package drd_pkg;

    localparam int DIV_BITS = 8;
    localparam int NS_BITS = 3 * DIV_BITS;
    localparam int PROD_BITS = 32;
    localparam int FUNC_BITS = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int DIM_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPACE_DIV = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_DIV = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_COUNT = 2'd3;

    localparam logic [FUNC_BITS-1:0] FUNC_TIME = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_X = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_Y = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_Z = 2'd3;

    localparam logic [DIM_BITS-1:0] DIM_TWO = 2'd2;
    localparam logic [DIM_BITS-1:0] DIM_THREE = 2'd3;

endpackage

/* sv/drd_if.sv */
`timescale 1ns / 1ps
interface drd_items_if #(parameter int RANK_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [RANK_BITS-1:0] rank;
    logic [1:0]           func;

    modport source (output valid, output rank, output func, input ready);
    modport sink (input valid, input rank, input func, output ready);
endinterface

interface drd_results_if #(parameter int RANK_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [7:0]           time_index;
    logic [15:0]          spatial_index;
    logic [7:0]           x_index;
    logic [7:0]           y_index;
    logic [7:0]           z_index;
    logic [RANK_BITS-1:0] seed_index;
    logic [7:0]           potential_index;
    logic [RANK_BITS-1:0] potential_seed;
    logic [RANK_BITS-1:0] next_rank;
    logic [RANK_BITS-1:0] prev_rank;
    logic                 domain_error;

    modport source (output valid, output time_index, output spatial_index, output x_index,
                    output y_index, output z_index, output seed_index, output potential_index,
                    output potential_seed, output next_rank, output prev_rank,
                    output domain_error, input ready);
    modport sink (input valid, input time_index, input spatial_index, input x_index,
                  input y_index, input z_index, input seed_index, input potential_index,
                  input potential_seed, input next_rank, input prev_rank,
                  input domain_error, output ready);
endinterface

/* sv/drd_div.sv */
`timescale 1ns / 1ps
module drd_div #(
    parameter int NB = 16,
    parameter int DB = 8,
    parameter int PB = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] dividend,
    input  logic [DB-1:0] divisor,
    input  logic [PB-1:0] in_payload,
    output logic          out_valid,
    output logic [NB-1:0] quotient,
    output logic [DB-1:0] remainder,
    output logic [PB-1:0] out_payload
);

    logic          v_reg [NB];
    logic [DB-1:0] r_reg [NB];
    logic [NB-1:0] q_reg [NB];
    logic [PB-1:0] p_reg [NB];

    genvar i;
    generate
        for (i = 0; i < NB; i++)
        begin : g_stage
            logic          v_in;
            logic [DB-1:0] r_in;
            logic [NB-1:0] q_in;
            logic [PB-1:0] p_in;
            logic [DB:0]   trial;
            logic          ge;
            logic [DB-1:0] r_next;
            logic [NB-1:0] q_next;

            if (i == 0)
            begin : g_first
                assign v_in = in_valid;
                assign r_in = '0;
                assign q_in = dividend;
                assign p_in = in_payload;
            end
            else
            begin : g_rest
                assign v_in = v_reg[i-1];
                assign r_in = r_reg[i-1];
                assign q_in = q_reg[i-1];
                assign p_in = p_reg[i-1];
            end

            // one quotient bit per stage
            always_comb
            begin
                trial = {r_in, q_in[NB-1]};
                ge = (trial >= {1'b0, divisor});
                r_next = ge ? DB'(trial - {1'b0, divisor}) : DB'(trial);
                q_next = {q_in[NB-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i] <= r_next;
                    q_reg[i] <= q_next;
                    p_reg[i] <= p_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NB-1];
    assign quotient = q_reg[NB-1];
    assign remainder = r_reg[NB-1];
    assign out_payload = p_reg[NB-1];

endmodule

/* sv/domain_rank_decomposer.sv */
`timescale 1ns / 1ps
// Decomposes a rank over the time/x/y/z domain grid and gives the periodic neighbours along
// the axis chosen by func. Fully pipelined: one transfer per cycle unless the result side stalls.
// The pipeline is five chained restoring dividers that each resolve one quotient bit per stage
// (rank by time count, by spatial count, by field count, then by x and y counts). A stall at
// the result side freezes the whole pipeline. Values derived from the registers settle once a
// configuration write has passed through the stride, span and error registers.
module domain_rank_decomposer #(
    parameter int RANK_BITS = 16,
    parameter int MAX_DIVISIONS = 255
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [drd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [drd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    drd_items_if.sink                            items,
    drd_results_if.source                        results
);

    localparam int RB = RANK_BITS;
    localparam int DV = drd_pkg::DIV_BITS;
    localparam int PW = drd_pkg::PROD_BITS;

    typedef struct packed {
        logic [1:0]    func;
        logic [RB-1:0] rank;
    } p1_t;

    typedef struct packed {
        logic [1:0]    func;
        logic [RB-1:0] rank;
        logic [DV-1:0] nt;
    } p2_t;

    typedef struct packed {
        logic [1:0]    func;
        logic [RB-1:0] rank;
        logic [DV-1:0] nt;
        logic [RB-1:0] ns;
        logic [RB-1:0] np;
    } p3_t;

    typedef struct packed {
        logic [1:0]    func;
        logic [RB-1:0] rank;
        logic [DV-1:0] nt;
        logic [RB-1:0] ns;
        logic [RB-1:0] np;
        logic [DV-1:0] nr;
        logic [RB-1:0] nq;
    } p4_t;

    typedef struct packed {
        logic [1:0]    func;
        logic [RB-1:0] rank;
        logic [DV-1:0] nt;
        logic [RB-1:0] ns;
        logic [RB-1:0] np;
        logic [DV-1:0] nr;
        logic [RB-1:0] nq;
        logic [DV-1:0] nx;
    } p5_t;

    logic [1:0]    dim_reg;
    logic [DV-1:0] sdiv_reg;
    logic [DV-1:0] tdiv_reg;
    logic [DV-1:0] fc_reg;

    logic [DV-1:0] nxd;
    logic [DV-1:0] nyd;
    logic [DV-1:0] nzd;
    logic [DV-1:0] ntd;
    logic [DV-1:0] fcd;

    logic [PW-1:0] s_y_reg;
    logic [PW-1:0] nxy_reg;
    logic [PW-1:0] s_z_reg;
    logic [PW-1:0] nsd_reg;
    logic [PW-1:0] w_x_reg;
    logic [PW-1:0] w_y_reg;
    logic [PW-1:0] w_z_reg;
    logic [PW-1:0] ntns_reg;
    logic          err_reg;

    logic          en;

    p1_t           p1;
    logic          d1_valid;
    logic [RB-1:0] d1_quo;
    logic [DV-1:0] d1_rem;
    p1_t           d1_pay;

    p2_t           p2;
    logic          d2_valid;
    logic [RB-1:0] d2_quo;
    logic [drd_pkg::NS_BITS-1:0] d2_rem;
    p2_t           d2_pay;

    p3_t           p3;
    logic          d3_valid;
    logic [RB-1:0] d3_quo;
    logic [DV-1:0] d3_rem;
    p3_t           d3_pay;

    p4_t           p4;
    logic          d4_valid;
    logic [RB-1:0] d4_quo;
    logic [DV-1:0] d4_rem;
    p4_t           d4_pay;

    p5_t           p5;
    logic          d5_valid;
    logic [RB-1:0] d5_quo;
    logic [DV-1:0] d5_rem;
    p5_t           d5_pay;

    logic [DV-1:0] ax_k;
    logic [DV-1:0] ax_c;
    logic [RB-1:0] ax_s;
    logic [RB-1:0] ax_w;
    logic [RB-1:0] nxt_next;
    logic [RB-1:0] prv_next;

    logic          out_valid_reg;
    logic [7:0]    nt_reg;
    logic [15:0]   ns_reg;
    logic [7:0]    nx_reg;
    logic [7:0]    ny_reg;
    logic [7:0]    nz_reg;
    logic [RB-1:0] np_reg;
    logic [7:0]    nr_reg;
    logic [RB-1:0] nq_reg;
    logic [RB-1:0] nxt_reg;
    logic [RB-1:0] prv_reg;
    logic          derr_reg;

    function automatic logic [DV-1:0] clamp_div(input logic [DV-1:0] v);
        logic [DV-1:0] r;
        if (v == '0)
        begin
            r = DV'(1);
        end
        else if (32'(v) > MAX_DIVISIONS)
        begin
            r = DV'(MAX_DIVISIONS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 2'd1;
            sdiv_reg <= DV'(1);
            tdiv_reg <= DV'(1);
            fc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                drd_pkg::REG_DIMENSION:   dim_reg <= cfg_data[1:0];
                drd_pkg::REG_SPACE_DIV:   sdiv_reg <= cfg_data;
                drd_pkg::REG_TIME_DIV:    tdiv_reg <= cfg_data;
                drd_pkg::REG_FIELD_COUNT: fc_reg <= cfg_data;
                default:                  dim_reg <= dim_reg;
            endcase
        end
    end

    always_comb
    begin
        nxd = clamp_div(sdiv_reg);
        nyd = (dim_reg >= drd_pkg::DIM_TWO) ? nxd : DV'(1);
        nzd = (dim_reg == drd_pkg::DIM_THREE) ? nxd : DV'(1);
        ntd = clamp_div(tdiv_reg);
        fcd = (fc_reg == '0) ? DV'(1) : fc_reg;
    end

    // strides and wrap spans per axis, one multiply deep per register
    always_ff @(posedge clk)
    begin
        s_y_reg <= PW'(nxd) * PW'(ntd);
        nxy_reg <= PW'(nxd) * PW'(nyd);
        s_z_reg <= s_y_reg * PW'(nyd);
        nsd_reg <= nxy_reg * PW'(nzd);
        w_x_reg <= PW'(nxd - DV'(1)) * PW'(ntd);
        w_y_reg <= PW'(nyd - DV'(1)) * s_y_reg;
        w_z_reg <= PW'(nzd - DV'(1)) * s_z_reg;
        ntns_reg <= nsd_reg * PW'(ntd);
        err_reg <= ({1'b0, ntns_reg} > (33'd1 << RB));
    end

    assign en = !(out_valid_reg && !results.ready);
    assign items.ready = en;

    assign p1.func = items.func;
    assign p1.rank = items.rank;

    // rank / Nt
    drd_div #(.NB(RB), .DB(DV), .PB($bits(p1_t))) u_div_t (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(items.valid), .dividend(items.rank), .divisor(ntd), .in_payload(p1),
        .out_valid(d1_valid), .quotient(d1_quo), .remainder(d1_rem), .out_payload(d1_pay)
    );

    assign p2.func = d1_pay.func;
    assign p2.rank = d1_pay.rank;
    assign p2.nt = d1_rem;

    // (rank / Nt) / Ns
    drd_div #(.NB(RB), .DB(drd_pkg::NS_BITS), .PB($bits(p2_t))) u_div_s (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d1_valid), .dividend(d1_quo), .divisor(drd_pkg::NS_BITS'(nsd_reg)),
        .in_payload(p2),
        .out_valid(d2_valid), .quotient(d2_quo), .remainder(d2_rem), .out_payload(d2_pay)
    );

    assign p3.func = d2_pay.func;
    assign p3.rank = d2_pay.rank;
    assign p3.nt = d2_pay.nt;
    assign p3.ns = RB'(d2_rem);
    assign p3.np = d2_quo;

    // seed over field count
    drd_div #(.NB(RB), .DB(DV), .PB($bits(p3_t))) u_div_f (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d2_valid), .dividend(d2_quo), .divisor(fcd), .in_payload(p3),
        .out_valid(d3_valid), .quotient(d3_quo), .remainder(d3_rem), .out_payload(d3_pay)
    );

    assign p4.func = d3_pay.func;
    assign p4.rank = d3_pay.rank;
    assign p4.nt = d3_pay.nt;
    assign p4.ns = d3_pay.ns;
    assign p4.np = d3_pay.np;
    assign p4.nr = d3_rem;
    assign p4.nq = d3_quo;

    // spatial index over Nx
    drd_div #(.NB(RB), .DB(DV), .PB($bits(p4_t))) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d3_valid), .dividend(d3_pay.ns), .divisor(nxd), .in_payload(p4),
        .out_valid(d4_valid), .quotient(d4_quo), .remainder(d4_rem), .out_payload(d4_pay)
    );

    assign p5.func = d4_pay.func;
    assign p5.rank = d4_pay.rank;
    assign p5.nt = d4_pay.nt;
    assign p5.ns = d4_pay.ns;
    assign p5.np = d4_pay.np;
    assign p5.nr = d4_pay.nr;
    assign p5.nq = d4_pay.nq;
    assign p5.nx = d4_rem;

    // remaining quotient over Ny gives y and z
    drd_div #(.NB(RB), .DB(DV), .PB($bits(p5_t))) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d4_valid), .dividend(d4_quo), .divisor(nyd), .in_payload(p5),
        .out_valid(d5_valid), .quotient(d5_quo), .remainder(d5_rem), .out_payload(d5_pay)
    );

    // neighbour: step by the axis stride, or wrap around over the whole axis at the edge
    always_comb
    begin
        case (d5_pay.func)
            drd_pkg::FUNC_TIME:
            begin
                ax_k = d5_pay.nt;
                ax_c = ntd;
                ax_s = RB'(1);
                ax_w = RB'(ntd - DV'(1));
            end
            drd_pkg::FUNC_X:
            begin
                ax_k = d5_pay.nx;
                ax_c = nxd;
                ax_s = RB'(ntd);
                ax_w = RB'(w_x_reg);
            end
            drd_pkg::FUNC_Y:
            begin
                ax_k = d5_rem;
                ax_c = nyd;
                ax_s = RB'(s_y_reg);
                ax_w = RB'(w_y_reg);
            end
            default:
            begin
                ax_k = DV'(d5_quo);
                ax_c = nzd;
                ax_s = RB'(s_z_reg);
                ax_w = RB'(w_z_reg);
            end
        endcase
        nxt_next = (ax_k == ax_c - DV'(1)) ? d5_pay.rank - ax_w : d5_pay.rank + ax_s;
        prv_next = (ax_k == '0) ? d5_pay.rank + ax_w : d5_pay.rank - ax_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d5_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nt_reg <= d5_pay.nt;
            ns_reg <= 16'(d5_pay.ns);
            nx_reg <= d5_pay.nx;
            ny_reg <= d5_rem;
            nz_reg <= 8'(d5_quo);
            np_reg <= d5_pay.np;
            nr_reg <= d5_pay.nr;
            nq_reg <= d5_pay.nq;
            nxt_reg <= nxt_next;
            prv_reg <= prv_next;
            derr_reg <= err_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.time_index = nt_reg;
    assign results.spatial_index = ns_reg;
    assign results.x_index = nx_reg;
    assign results.y_index = ny_reg;
    assign results.z_index = nz_reg;
    assign results.seed_index = np_reg;
    assign results.potential_index = nr_reg;
    assign results.potential_seed = nq_reg;
    assign results.next_rank = nxt_reg;
    assign results.prev_rank = prv_reg;
    assign results.domain_error = derr_reg;

endmodule

/* sv/drd_checker.sv */
`timescale 1ns / 1ps
module drd_checker #(
    parameter int RANK_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [RANK_BITS-1:0] next_rank
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(next_rank))
        else $error("result changed while stalled");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline frozen");

    a_free_flows: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input refused while pipeline free");

endmodule

bind domain_rank_decomposer drd_checker #(.RANK_BITS(RANK_BITS)) u_drd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(items.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .next_rank(results.next_rank)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [7:0]  time_index;
        logic [15:0] spatial_index;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  z_index;
        logic [15:0] seed_index;
        logic [7:0]  potential_index;
        logic [15:0] potential_seed;
        logic [15:0] next_rank;
        logic [15:0] prev_rank;
        logic        domain_error;
    } grid_pos_t;

    typedef struct {
        int          setting;
        logic [15:0] rank;
        logic [1:0]  func;
        bit          typed;
        grid_pos_t   pos;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [drd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [drd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    drd_items_if #(.RANK_BITS(16)) itm ();
    drd_results_if #(.RANK_BITS(16)) res ();

    domain_rank_decomposer #(.RANK_BITS(16), .MAX_DIVISIONS(255)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .items(itm.sink),
        .results(res.source)
    );

    logic [7:0] g_dim, g_space, g_time, g_fields;
    grid_pos_t pending_pos[$];
    int errors;
    int transfers_in;
    int transfers_out;
    int src_idle;
    int snk_idle;
    int hold_left;

    // table of register settings: dimension, space, time, field count
    logic [7:0] settings[5][4] = '{
        '{8'd1, 8'd1, 8'd1, 8'd0},
        '{8'd3, 8'd255, 8'd255, 8'd255},
        '{8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd2, 8'd16, 8'd4, 8'd3},
        '{8'd3, 8'd5, 8'd3, 8'd7}
    };

    function automatic grid_pos_t locate(logic [15:0] rank, logic [1:0] func);
        longint unsigned dx, dy, dz, dt, ds, dts;
        longint unsigned nt, ns, nx, ny, nz, np, base, nxt, prv;
        grid_pos_t p;
        dx = (g_space == 0) ? 1 : g_space;
        dy = (g_dim >= 2) ? dx : 1;
        dz = (g_dim == 3) ? dx : 1;
        dt = (g_time == 0) ? 1 : g_time;
        ds = dx * dy * dz;
        dts = dt * ds;
        nt = rank % dt;
        ns = (rank / dt) % ds;
        nx = ns % dx;
        ny = (ns / dx) % dy;
        nz = ns / (dx * dy);
        np = rank / dts;
        base = np * dts;
        case (func)
            drd_pkg::FUNC_TIME:
            begin
                nxt = (nt + 1) % dt + ns * dt + base;
                prv = (nt + dt - 1) % dt + ns * dt + base;
            end
            drd_pkg::FUNC_X:
            begin
                nxt = nt + ((nx + 1) % dx + ny * dx + nz * dx * dy) * dt + base;
                prv = nt + ((nx + dx - 1) % dx + ny * dx + nz * dx * dy) * dt + base;
            end
            drd_pkg::FUNC_Y:
            begin
                nxt = nt + (nx + ((ny + 1) % dy) * dx + nz * dx * dy) * dt + base;
                prv = nt + (nx + ((ny + dy - 1) % dy) * dx + nz * dx * dy) * dt + base;
            end
            default:
            begin
                nxt = nt + (nx + ny * dx + ((nz + 1) % dz) * dx * dy) * dt + base;
                prv = nt + (nx + ny * dx + ((nz + dz - 1) % dz) * dx * dy) * dt + base;
            end
        endcase
        p.time_index = nt[7:0];
        p.spatial_index = ns[15:0];
        p.x_index = nx[7:0];
        p.y_index = ny[7:0];
        p.z_index = nz[7:0];
        p.seed_index = np[15:0];
        p.potential_index = (g_fields == 0) ? 8'd0 : 8'(np % g_fields);
        p.potential_seed = (g_fields == 0) ? np[15:0] : 16'(np / g_fields);
        p.next_rank = nxt[15:0];
        p.prev_rank = prv[15:0];
        p.domain_error = (dts > 65536);
        return p;
    endfunction

    function automatic int grid_span();
        longint unsigned dx, ds;
        dx = (g_space == 0) ? 1 : g_space;
        ds = dx * ((g_dim >= 2) ? dx : 1) * ((g_dim == 3) ? dx : 1);
        ds = ds * ((g_time == 0) ? 1 : g_time) * 3;
        return (ds > 65535) ? 65535 : int'(ds);
    endfunction

    task automatic compare(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic write_reg(logic [drd_pkg::CFG_INDEX_BITS-1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            drd_pkg::REG_DIMENSION: g_dim = val & 8'd3;
            drd_pkg::REG_SPACE_DIV: g_space = val;
            drd_pkg::REG_TIME_DIV: g_time = val;
            drd_pkg::REG_FIELD_COUNT: g_fields = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [7:0] dim, logic [7:0] sp, logic [7:0] tm, logic [7:0] fc);
        wait (pending_pos.size() == 0);
        repeat (90) @(negedge clk);
        write_reg(drd_pkg::REG_DIMENSION, dim);
        write_reg(drd_pkg::REG_SPACE_DIV, sp);
        write_reg(drd_pkg::REG_TIME_DIV, tm);
        write_reg(drd_pkg::REG_FIELD_COUNT, fc);
        cfg_we <= 1'b0;
        repeat (8) @(negedge clk);
    endtask

    task automatic send(logic [15:0] rank, logic [1:0] func, bit typed, grid_pos_t pos);
        while ($urandom_range(99) < src_idle)
        begin
            itm.valid <= 1'b0;
            @(negedge clk);
        end
        itm.valid <= 1'b1;
        itm.rank <= rank;
        itm.func <= func;
        do
            @(posedge clk);
        while (!itm.ready);
        pending_pos.push_back(typed ? pos : locate(rank, func));
        transfers_in++;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // sink side with random stalls and one long hold-off
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        grid_pos_t e;
        if (rst_n && res.valid && res.ready)
        begin
            transfers_out++;
            if (pending_pos.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transfer, next_rank %0d", $time, res.next_rank);
            end
            else
            begin
                e = pending_pos.pop_front();
                compare("time_index", e.time_index, res.time_index);
                compare("spatial_index", e.spatial_index, res.spatial_index);
                compare("x_index", e.x_index, res.x_index);
                compare("y_index", e.y_index, res.y_index);
                compare("z_index", e.z_index, res.z_index);
                compare("seed_index", e.seed_index, res.seed_index);
                compare("potential_index", e.potential_index, res.potential_index);
                compare("potential_seed", e.potential_seed, res.potential_seed);
                compare("next_rank", e.next_rank, res.next_rank);
                compare("prev_rank", e.prev_rank, res.prev_rank);
                compare("domain_error", e.domain_error, res.domain_error);
            end
        end
    end

    initial
    begin
        vector_t vectors[$];
        int cur;
        int span;
        logic [15:0] r;
        grid_pos_t none;
        none = '0;
        errors = 0;
        transfers_in = 0;
        transfers_out = 0;
        hold_left = 0;
        src_idle = 0;
        snk_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        itm.valid = 1'b0;
        itm.rank = '0;
        itm.func = drd_pkg::FUNC_TIME;
        g_dim = 8'd1;
        g_space = 8'd1;
        g_time = 8'd1;
        g_fields = 8'd0;

        // reset values: every rank is its own neighbour, all in seed index
        vectors.push_back('{0, 16'd0, drd_pkg::FUNC_TIME, 1'b1,
            '{8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0}});
        vectors.push_back('{0, 16'd65535, drd_pkg::FUNC_X, 1'b1,
            '{8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 16'd65535, 8'd0, 16'd65535, 16'd65535,
              16'd65535, 1'b0}});
        vectors.push_back('{0, 16'd1, drd_pkg::FUNC_Y, 1'b1,
            '{8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd0, 16'd1, 16'd1, 16'd1, 1'b0}});
        vectors.push_back('{0, 16'd32768, drd_pkg::FUNC_Z, 1'b1,
            '{8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 16'd32768, 8'd0, 16'd32768, 16'd32768,
              16'd32768, 1'b0}});
        // oversized grid
        vectors.push_back('{1, 16'd65535, drd_pkg::FUNC_TIME, 1'b0, none});
        vectors.push_back('{1, 16'd65535, drd_pkg::FUNC_X, 1'b0, none});
        vectors.push_back('{1, 16'd65535, drd_pkg::FUNC_Y, 1'b0, none});
        vectors.push_back('{1, 16'd65535, drd_pkg::FUNC_Z, 1'b0, none});
        vectors.push_back('{1, 16'd0, drd_pkg::FUNC_Z, 1'b0, none});
        vectors.push_back('{1, 16'd254, drd_pkg::FUNC_TIME, 1'b0, none});
        // zero dimension and zero divisions
        vectors.push_back('{2, 16'd12345, drd_pkg::FUNC_Y, 1'b0, none});
        vectors.push_back('{2, 16'd7, drd_pkg::FUNC_TIME, 1'b0, none});
        vectors.push_back('{2, 16'd65535, drd_pkg::FUNC_X, 1'b0, none});
        // two dimensions, field count in use
        vectors.push_back('{3, 16'd0, drd_pkg::FUNC_TIME, 1'b0, none});
        vectors.push_back('{3, 16'd63, drd_pkg::FUNC_X, 1'b0, none});
        vectors.push_back('{3, 16'd64, drd_pkg::FUNC_Y, 1'b0, none});
        vectors.push_back('{3, 16'd1023, drd_pkg::FUNC_Z, 1'b0, none});
        vectors.push_back('{3, 16'd65535, drd_pkg::FUNC_Y, 1'b0, none});
        vectors.push_back('{3, 16'd1024, drd_pkg::FUNC_X, 1'b0, none});
        // three dimensions
        vectors.push_back('{4, 16'd374, drd_pkg::FUNC_Z, 1'b0, none});
        vectors.push_back('{4, 16'd0, drd_pkg::FUNC_Z, 1'b0, none});
        vectors.push_back('{4, 16'd65535, drd_pkg::FUNC_Y, 1'b0, none});
        vectors.push_back('{4, 16'd375, drd_pkg::FUNC_X, 1'b0, none});

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        cur = 0;
        foreach (vectors[i])
        begin
            if (vectors[i].setting != cur)
            begin
                itm.valid <= 1'b0;
                @(negedge clk);
                cur = vectors[i].setting;
                configure(settings[cur][0], settings[cur][1], settings[cur][2], settings[cur][3]);
            end
            send(vectors[i].rank, vectors[i].func, vectors[i].typed, vectors[i].pos);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            itm.valid <= 1'b0;
            @(negedge clk);
            case (ph)
                0: configure(8'd3, 8'd255, 8'd255, 8'd255);
                1: configure(8'd1, 8'd255, 8'd1, 8'd1);
                2: configure(8'd3, 8'd40, 8'd41, 8'd0);
                3: configure(8'd0, 8'd0, 8'd0, 8'd0);
                default: configure(8'($urandom_range(3)), 8'($urandom_range(0, 20)),
                                   8'($urandom_range(0, 20)), 8'($urandom_range(0, 255)));
            endcase
            span = grid_span();
            for (int k = 0; k < 235; k++)
            begin
                if (transfers_in < 650)
                begin
                    src_idle = 10;
                    snk_idle = 81;
                end
                else if (transfers_in < 1300)
                begin
                    src_idle = 81;
                    snk_idle = 10;
                end
                else
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                if (ph == 2 && k == 40)
                    hold_left = 400;
                if (ph == 5 && k == 100)
                begin
                    itm.valid <= 1'b0;
                    @(negedge clk);
                    wait (pending_pos.size() == 0);
                    @(negedge clk);
                end
                r = ($urandom_range(9) < 3) ? 16'($urandom_range(0, span)) : 16'($urandom);
                send(r, 2'($urandom_range(3)), 1'b0, none);
            end
        end

        itm.valid <= 1'b0;
        wait (pending_pos.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d ranks sent and %0d decompositions checked over directed and random settings,",
                 transfers_in, transfers_out);
        $display("covering all four axes, zero and full-scale divisions and oversized grids");
        if (errors == 0 && pending_pos.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* files.f */
sv/drd_pkg.sv
sv/drd_if.sv
sv/drd_div.sv
sv/domain_rank_decomposer.sv
sv/drd_checker.sv
tb/sv/tb_top.sv
